// ===== design/uct_pkg.sv =====
// Package for the unicode transcoder: mode codes, the result set type and
// the UTF-8 and UTF-16 encoding functions.
// Depends on nothing; it is imported by every module of the block.
`default_nettype none

package uct_pkg;

	// Operating modes, as written through the configuration port.
	typedef enum logic [1:0] {
		MODE_U8_U16 = 2'd0,
		MODE_U8_U32 = 2'd1,
		MODE_U16_U8 = 2'd2,
		MODE_U32_U8 = 2'd3
	} mode_t;

	localparam int MAX_RESULTS = 6;
	localparam int UNIT_W      = 31;

	// Lead byte marks of the two-to-six-byte UTF-8 forms.
	localparam logic [7:0] MARK2 = 8'hC0;
	localparam logic [7:0] MARK3 = 8'hE0;
	localparam logic [7:0] MARK4 = 8'hF0;
	localparam logic [7:0] MARK5 = 8'hF8;
	localparam logic [7:0] MARK6 = 8'hFC;

	localparam logic [31:0] PAIR_BASE   = 32'h0001_0000;
	localparam logic [31:0] MAX_U16_CP  = 32'h0010_FFFF;
	localparam logic [31:0] MAX_U8_CP   = 32'h7FFF_FFFF;
	localparam logic [31:0] LAST_BMP_LO = 32'h0000_D7FF;
	localparam logic [15:0] HIGH_SURR   = 16'hD800;
	localparam logic [15:0] LOW_SURR    = 16'hDC00;
	localparam logic [15:0] SURR_MASK   = 16'hFC00;
	localparam logic [9:0]  TEN_BITS    = 10'h3FF;

	// Up to six output elements of one input item, lowest slot first.
	typedef struct packed {
		logic [2:0]                             cnt;
		logic [MAX_RESULTS-1:0][UNIT_W-1:0]     u;
	} res_set_t;

	localparam res_set_t RES_EMPTY = '{cnt: 3'd0, u: '0};

	// One element on its own.
	function automatic res_set_t single(input logic [UNIT_W-1:0] v);
		res_set_t r;
		r      = RES_EMPTY;
		r.cnt  = 3'd1;
		r.u[0] = v;
		return r;
	endfunction

	// Append the elements of b behind those of a (at most six in total).
	function automatic res_set_t append(input res_set_t a, input res_set_t b);
		res_set_t   r;
		logic [2:0] k;
		r     = a;
		r.cnt = a.cnt + b.cnt;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			k = 3'(i) - a.cnt;
			if (3'(i) >= a.cnt && k < 3'(MAX_RESULTS)) begin
				r.u[i] = b.u[k];
			end
		end
		return r;
	endfunction

	// UTF-8 encoding in the original forms of up to six bytes.
	function automatic res_set_t enc8(input logic [31:0] cp);
		res_set_t    r;
		logic [2:0]  k;
		logic [7:0]  mark;
		logic [35:0] ext;
		logic [2:0]  sel;
		logic [5:0]  grp;
		logic [7:0]  byte_v;
		r    = RES_EMPTY;
		ext  = {4'b0000, cp};
		mark = 8'h00;
		if (cp == 32'd0) begin
			k = 3'd0;
		end else if (cp <= 32'h0000_007F) begin
			k = 3'd1;
		end else if (cp <= 32'h0000_07FF) begin
			k = 3'd2;
			mark = MARK2;
		end else if (cp <= 32'h0000_FFFF) begin
			k = 3'd3;
			mark = MARK3;
		end else if (cp <= 32'h001F_FFFF) begin
			k = 3'd4;
			mark = MARK4;
		end else if (cp <= 32'h03FF_FFFF) begin
			k = 3'd5;
			mark = MARK5;
		end else if (cp <= MAX_U8_CP) begin
			k = 3'd6;
			mark = MARK6;
		end else begin
			k = 3'd0;
		end
		r.cnt = k;
		for (int j = 0; j < MAX_RESULTS; j++) begin
			if (3'(j) < k) begin
				sel = k - 3'd1 - 3'(j);
				grp = ext[6*sel +: 6];
				if (j == 0) begin
					byte_v = (k == 3'd1) ? cp[7:0] : (mark | {2'b00, grp});
				end else begin
					byte_v = {2'b10, grp};
				end
				r.u[j] = UNIT_W'(byte_v);
			end
		end
		return r;
	endfunction

	// UTF-16 encoding; zero, surrogate values and values beyond the last plane give nothing.
	function automatic res_set_t enc16(input logic [UNIT_W-1:0] cp);
		res_set_t    r;
		logic [31:0] v;
		logic [31:0] c;
		r = RES_EMPTY;
		c = 32'(cp);
		v = c - PAIR_BASE;
		if (c == 32'd0) begin
			r = RES_EMPTY;
		end else if (c <= LAST_BMP_LO || (c >= 32'h0000_E000 && c <= 32'h0000_FFFF)) begin
			r = single(cp);
		end else if (c >= PAIR_BASE && c <= MAX_U16_CP) begin
			r.cnt  = 3'd2;
			r.u[0] = UNIT_W'(HIGH_SURR | {6'b0, v[19:10]});
			r.u[1] = UNIT_W'(LOW_SURR | {6'b0, v[9:0]});
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/unicode_transcoder.sv =====
// Streaming UTF-8 / UTF-16 / UTF-32 transcoder. The first result of an
// element passes through the input register, then the result register.
// Throughput: one element per cycle, unless the output is held back, while
// each gives at most one result; one with more results holds the input
// until its last result leaves the result register's single output.
// Reset clears the mode to UTF-8 to UTF-16 and empties all decoder state.
`default_nettype none

module unicode_transcoder
	import uct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // code_unit[31:0]
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // out_unit[31:0]
	output logic             m_tlast    // run_last
);

	logic        valid_s1;
	logic [31:0] unit_s1;
	logic        eot_s1;
	logic        free;
	logic        advance;
	res_set_t    res;

	// The input register moves on whenever the result register can take it.
	assign advance  = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			unit_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	uct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.unit      (unit_s1),
		.eot       (eot_s1),
		.res       (res)
	);

	uct_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== design/uct_core.sv =====
// Conversion core of the unicode transcoder: mode register, decoder state
// and the single-pass logic that turns one element into its result set.
// Depends on uct_pkg.
`default_nettype none

module uct_core
	import uct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        step,
	input  wire logic [31:0] unit,
	input  wire logic        eot,
	output res_set_t         res
);

	mode_t        mode_q;
	logic [2:0]   pend_q, pend_d;
	logic [30:0]  part_q, part_d;
	logic [15:0]  held_q, held_d;
	logic         held_vld_q, held_vld_d;

	logic [7:0]   b;
	logic [15:0]  u;
	logic         fire;
	logic [30:0]  cp;
	logic         u_high, u_low, done;
	res_set_t     set_a, set_b;

	assign b      = unit[7:0];
	assign u      = unit[15:0];
	assign u_high = (u & SURR_MASK) == HIGH_SURR;
	assign u_low  = (u & SURR_MASK) == LOW_SURR;

	// Next state and results for the element in the input register.
	always_comb begin
		pend_d     = pend_q;
		part_d     = part_q;
		held_d     = held_q;
		held_vld_d = held_vld_q;
		fire       = 1'b0;
		cp         = '0;
		done       = 1'b0;
		set_a      = RES_EMPTY;
		set_b      = RES_EMPTY;
		res        = RES_EMPTY;
		case (mode_q)
			MODE_U8_U16, MODE_U8_U32: begin
				if (pend_q != 3'd0) begin
					part_d = {part_q[24:0], b[5:0]};
					pend_d = pend_q - 3'd1;
					if (pend_q == 3'd1) begin
						fire = 1'b1;
						cp   = part_d;
					end
				end else if ((b & 8'hFE) == MARK6) begin
					part_d = 31'(b[0]);
					pend_d = 3'd5;
				end else if ((b & 8'hFC) == MARK5) begin
					part_d = 31'(b[1:0]);
					pend_d = 3'd4;
				end else if ((b & 8'hF8) == MARK4) begin
					part_d = 31'(b[2:0]);
					pend_d = 3'd3;
				end else if ((b & 8'hF0) == MARK3) begin
					part_d = 31'(b[3:0]);
					pend_d = 3'd2;
				end else if ((b & 8'hE0) == MARK2) begin
					part_d = 31'(b[4:0]);
					pend_d = 3'd1;
				end else if (b[7:6] == 2'b10) begin
					// A stray continuation byte gives its low six bits.
					fire = 1'b1;
					cp   = 31'(b[5:0]);
				end else begin
					fire = 1'b1;
					cp   = 31'(b);
				end
				if (eot) begin
					pend_d = 3'd0;
					part_d = '0;
				end
				if (fire) begin
					if (mode_q == MODE_U8_U16) begin
						res = enc16(cp);
					end else if (cp != '0) begin
						res = single(cp);
					end
				end
			end
			MODE_U16_U8: begin
				// A held high surrogate either pairs with a low one or goes out alone.
				if (held_vld_q) begin
					if (u_low) begin
						set_a = enc8(PAIR_BASE + 32'({held_q[9:0] & TEN_BITS, u[9:0]}));
						done  = 1'b1;
					end else begin
						set_a = enc8(32'(held_q));
					end
				end
				// A new high surrogate is held, unless the text ends here.
				if (!done && (!u_high || eot)) begin
					set_b = enc8(32'(u));
				end
				held_vld_d = !done && u_high && !eot;
				held_d     = held_vld_d ? u : 16'h0000;
				res        = append(set_a, set_b);
			end
			default: begin
				res = enc8(unit);
			end
		endcase
	end

	// Mode register and decoder state; a mode write clears the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_U8_U16;
			pend_q     <= 3'd0;
			part_q     <= '0;
			held_q     <= 16'h0000;
			held_vld_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q     <= mode_t'(cfg_wdata);
			pend_q     <= 3'd0;
			part_q     <= '0;
			held_q     <= 16'h0000;
			held_vld_q <= 1'b0;
		end else if (step) begin
			pend_q     <= pend_d;
			part_q     <= part_d;
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/uct_outbuf.sv =====
// Result register of the unicode transcoder: holds the result set of one
// element and hands its elements out one transaction at a time.
// Depends on uct_pkg.
`default_nettype none

module uct_outbuf
	import uct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire res_set_t    res,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_unit[31:0]
	output logic             m_tlast   // run_last
);

	logic [MAX_RESULTS-1:0][UNIT_W-1:0] units_q;
	logic [2:0]                         cnt_q;
	logic [2:0]                         idx_q;
	logic                               take;

	// The register is free when empty or when its last element leaves now.
	assign m_tvalid = cnt_q != 3'd0;
	assign m_tlast  = idx_q == (cnt_q - 3'd1);
	assign m_tdata  = {1'b0, units_q[idx_q]};
	assign take     = m_tvalid && m_tready;
	assign free     = !m_tvalid || (m_tready && m_tlast);

	// Count and position of the element on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
			idx_q <= 3'd0;
		end else if (take) begin
			if (m_tlast) begin
				cnt_q <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Result elements.
	always_ff @(posedge clk) begin
		if (load) begin
			units_q <= res.u;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_unicode_transcoder.sv =====
// Self-checking testbench for the unicode transcoder: a directed table, then random text
// in all four modes under changing idle patterns, each checked against an in-bench predictor.
// Depends on uct_pkg for the mode codes and the encoding constants, and on unicode_transcoder.
module tb_unicode_transcoder
	import uct_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COMPUTED      = -1;     // expected results come from the predictor
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_STALL    = 80;
	localparam int PHASE_ITEMS   = 14;     // input transactions per mode and idle pattern, at the least
	localparam int CYCLE_LIMIT   = 300000;

	typedef struct {
		logic [31:0] unit;
		logic        last;
	} out_item_t;

	typedef struct {
		mode_t       mode;
		logic [31:0] unit;
		logic        eot;
		int          want_n;
		logic [31:0] want;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = 32'd0;   // code_unit[31:0]
	logic        s_tlast   = 1'b0;    // end_of_text
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;             // out_unit[31:0]
	logic        m_tlast;             // run_last

	// Predictor state and its output of one step.
	mode_t       cur_mode  = MODE_U8_U16;
	logic [2:0]  cont_left = 3'd0;
	logic [30:0] acc_point = 31'd0;
	logic [15:0] high_surr = 16'd0;
	logic        high_held = 1'b0;
	logic [31:0] tc_units [6];
	int          tc_count;
	logic [7:0]  form_b [6];
	int          form_n;

	out_item_t   pending_units [$];
	int          mismatches    = 0;
	int          sent_items    = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        stall_req     = 1'b0;
	logic        stall_seen    = 1'b0;
	int          stall_left    = 0;
	int unsigned cycle_count   = 0;

	// Directed table: extremes, every mode and the special cases of the decoder.
	stim_row_t dir_rows [$] = '{
		'{MODE_U8_U16, 32'h0000_0041, 1'b0, 1, 32'h0000_0041},        // plain ASCII
		'{MODE_U8_U16, 32'hFFFF_FF00, 1'b0, 0, 32'h0},                // code point zero, junk above
		'{MODE_U8_U16, 32'h0000_00BF, 1'b0, 1, 32'h0000_003F},        // stray continuation
		'{MODE_U8_U16, 32'h0000_00FE, 1'b0, 1, 32'h0000_00FE},        // stray 0xFE
		'{MODE_U8_U16, 32'h0000_00F4, 1'b0, COMPUTED, 32'h0},         // last plane point: pair
		'{MODE_U8_U16, 32'h0000_008F, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U16, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U16, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U16, 32'h0000_00ED, 1'b0, COMPUTED, 32'h0},         // lead byte taken as a
		'{MODE_U8_U16, 32'h0000_00E0, 1'b0, COMPUTED, 32'h0},         // continuation, giving a
		'{MODE_U8_U16, 32'h0000_0080, 1'b0, COMPUTED, 32'h0},         // surrogate that is dropped
		'{MODE_U8_U16, 32'h0000_00C3, 1'b1, 0, 32'h0},                // open sequence dropped
		'{MODE_U8_U16, 32'h0000_0080, 1'b0, 0, 32'h0},                // now a stray zero
		'{MODE_U8_U16, 32'h0000_00E2, 1'b0, COMPUTED, 32'h0},         // cleared by the mode write
		'{MODE_U8_U32, 32'h0000_00FD, 1'b0, COMPUTED, 32'h0},         // six-byte form, top value
		'{MODE_U8_U32, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U32, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U32, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U32, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U32, 32'h0000_00BF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U8_U32, 32'h0000_00FF, 1'b1, 1, 32'h0000_00FF},        // stray 0xFF at end of text
		'{MODE_U16_U8, 32'hFFFF_D800, 1'b0, 0, 32'h0},                // high surrogate held
		'{MODE_U16_U8, 32'h0000_0041, 1'b0, COMPUTED, 32'h0},         // unpaired, then ASCII
		'{MODE_U16_U8, 32'h0000_DBFF, 1'b0, COMPUTED, 32'h0},         // proper pair
		'{MODE_U16_U8, 32'h0000_DFFF, 1'b0, COMPUTED, 32'h0},
		'{MODE_U16_U8, 32'h0000_DC00, 1'b0, COMPUTED, 32'h0},         // lone low surrogate
		'{MODE_U16_U8, 32'h0000_D800, 1'b1, COMPUTED, 32'h0},         // flushed by end of text
		'{MODE_U32_U8, 32'hFFFF_FFFF, 1'b0, 0, 32'h0},                // beyond the six-byte range
		'{MODE_U32_U8, 32'h7FFF_FFFF, 1'b0, COMPUTED, 32'h0}
	};

	int send_idle_by [3] = '{26, 66, 0};
	int recv_idle_by [3] = '{66, 26, 0};

	unicode_transcoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock of 10 ns.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// UTF-8 bytes of one code point in the original forms of up to six bytes.
	function automatic void utf8_form(input logic [31:0] cp);
		int         len;
		logic [7:0] mark;
		form_n = 0;
		if (cp == 32'd0 || cp > MAX_U8_CP) begin
			return;
		end
		if (cp <= 32'h7F) begin
			form_b[0] = cp[7:0];
			form_n    = 1;
			return;
		end
		if (cp <= 32'h7FF) begin
			len  = 2;
			mark = MARK2;
		end else if (cp <= 32'hFFFF) begin
			len  = 3;
			mark = MARK3;
		end else if (cp <= 32'h1F_FFFF) begin
			len  = 4;
			mark = MARK4;
		end else if (cp <= 32'h3FF_FFFF) begin
			len  = 5;
			mark = MARK5;
		end else begin
			len  = 6;
			mark = MARK6;
		end
		form_b[0] = mark | 8'(cp >> (6 * (len - 1)));
		for (int i = 1; i < len; i++) begin
			form_b[i] = 8'h80 | {2'b00, 6'(cp >> (6 * (len - 1 - i)))};
		end
		form_n = len;
	endfunction

	function automatic void add_unit(input logic [31:0] v);
		tc_units[tc_count] = v;
		tc_count++;
	endfunction

	function automatic void add_utf8(input logic [31:0] cp);
		utf8_form(cp);
		for (int i = 0; i < form_n; i++) begin
			add_unit({24'd0, form_b[i]});
		end
	endfunction

	// A decoded code point leaves as UTF-16 units in mode 0, as itself in mode 1.
	function automatic void deliver_point(input logic [31:0] cp);
		logic [31:0] v;
		v = cp - PAIR_BASE;
		if (cp == 32'd0) begin
			return;
		end
		if (cur_mode != MODE_U8_U16) begin
			add_unit(cp);
		end else if (cp <= LAST_BMP_LO || (cp >= 32'hE000 && cp <= 32'hFFFF)) begin
			add_unit(cp);
		end else if (cp >= PAIR_BASE && cp <= MAX_U16_CP) begin
			add_unit({16'd0, HIGH_SURR | {6'd0, v[19:10]}});
			add_unit({16'd0, LOW_SURR | {6'd0, v[9:0]}});
		end
	endfunction

	// Predicts the output units caused by one input transaction and advances the state.
	function automatic void transcode(input logic [31:0] unit, input logic eot);
		logic [7:0]  b;
		logic [15:0] u;
		logic        paired;
		b        = unit[7:0];
		u        = unit[15:0];
		paired   = 1'b0;
		tc_count = 0;
		case (cur_mode)
			MODE_U8_U16, MODE_U8_U32: begin
				if (cont_left != 3'd0) begin
					acc_point = {acc_point[24:0], b[5:0]};
					cont_left = cont_left - 3'd1;
					if (cont_left == 3'd0) begin
						deliver_point({1'b0, acc_point});
					end
				end else if ((b & 8'hFE) == MARK6) begin
					acc_point = 31'(b[0]);
					cont_left = 3'd5;
				end else if ((b & 8'hFC) == MARK5) begin
					acc_point = 31'(b[1:0]);
					cont_left = 3'd4;
				end else if ((b & 8'hF8) == MARK4) begin
					acc_point = 31'(b[2:0]);
					cont_left = 3'd3;
				end else if ((b & 8'hF0) == MARK3) begin
					acc_point = 31'(b[3:0]);
					cont_left = 3'd2;
				end else if ((b & 8'hE0) == MARK2) begin
					acc_point = 31'(b[4:0]);
					cont_left = 3'd1;
				end else if (b[7:6] == 2'b10) begin
					deliver_point({26'd0, b[5:0]});
				end else begin
					deliver_point({24'd0, b});
				end
				if (eot) begin
					cont_left = 3'd0;
					acc_point = 31'd0;
				end
			end
			MODE_U16_U8: begin
				if (high_held) begin
					if ((u & SURR_MASK) == LOW_SURR) begin
						add_utf8(PAIR_BASE + {12'd0, high_surr[9:0], u[9:0]});
						paired = 1'b1;
					end else begin
						add_utf8({16'd0, high_surr});
					end
					high_held = 1'b0;
					high_surr = 16'd0;
				end
				if (!paired) begin
					if ((u & SURR_MASK) == HIGH_SURR) begin
						high_surr = u;
						high_held = 1'b1;
					end else begin
						add_utf8({16'd0, u});
					end
				end
				if (eot && high_held) begin
					add_utf8({16'd0, high_surr});
					high_held = 1'b0;
					high_surr = 16'd0;
				end
			end
			default: begin
				add_utf8(unit);
			end
		endcase
	endfunction

	// Random code point spread over every encoded length, sometimes beyond all of them.
	function automatic logic [31:0] rand_point();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 32'h7F);
			1: return $urandom_range(32'h80, 32'h7FF);
			2: return $urandom_range(32'h800, 32'hFFFF);
			3: return $urandom_range(32'h1_0000, 32'h10_FFFF);
			4: return $urandom_range(32'h11_0000, 32'h1F_FFFF);
			5: return $urandom_range(32'h20_0000, 32'h3FF_FFFF);
			6: return $urandom_range(32'h400_0000, 32'h7FFF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Now and then sets the input bits that the current mode ignores.
	function automatic logic [31:0] with_junk(input logic [31:0] v, input int kept);
		if ($urandom_range(0, 3) == 0) begin
			return v | (32'($urandom) << kept);
		end
		return v;
	endfunction

	function automatic logic rand_eot();
		return $urandom_range(0, 11) == 0;
	endfunction

	// One input transaction, with a random gap ahead of it; expectations are queued on acceptance.
	task automatic send_item(input logic [31:0] unit, input logic eot, input int want_n,
			input logic [31:0] want);
		logic      taken;
		out_item_t item;
		taken = 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= unit;
		s_tlast  <= eot;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		sent_items++;
		transcode(unit, eot);
		if (want_n == COMPUTED) begin
			for (int i = 0; i < tc_count; i++) begin
				item.unit = tc_units[i];
				item.last = (i == tc_count - 1);
				pending_units.push_back(item);
			end
		end else if (want_n == 1) begin
			item.unit = want;
			item.last = 1'b1;
			pending_units.push_back(item);
		end
	endtask

	// Stops offering input and waits until every expected unit has arrived and the block is quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_units.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode  = m;
		cont_left = 3'd0;
		acc_point = 31'd0;
		high_surr = 16'd0;
		high_held = 1'b0;
	endtask

	// One character of random text for the given mode: mostly well formed, the rest noise.
	task automatic send_text(input mode_t m);
		logic [7:0]  seq [6];
		int          seq_n;
		logic [31:0] cp;
		logic [31:0] v;
		logic        good;
		good = $urandom_range(0, 99) < 80;
		cp   = rand_point();
		case (m)
			MODE_U8_U16, MODE_U8_U32: begin
				utf8_form(cp);
				seq_n = form_n;
				for (int i = 0; i < form_n; i++) begin
					seq[i] = form_b[i];
				end
				if (!good || seq_n == 0) begin
					seq_n = $urandom_range(1, 3);
					for (int i = 0; i < seq_n; i++) begin
						seq[i] = 8'($urandom_range(0, 255));
					end
				end
				for (int i = 0; i < seq_n; i++) begin
					send_item(with_junk({24'd0, seq[i]}, 8), (i == seq_n - 1) && rand_eot(),
						COMPUTED, 32'd0);
				end
			end
			MODE_U16_U8: begin
				if (!good) begin
					v = $urandom_range(0, 1) ? $urandom_range(32'hD800, 32'hDFFF)
						: $urandom_range(0, 32'hFFFF);
					send_item(with_junk(v, 16), rand_eot(), COMPUTED, 32'd0);
				end else begin
					cp = cp % 32'h11_0000;
					if (cp >= PAIR_BASE) begin
						v = cp - PAIR_BASE;
						send_item(with_junk({16'd0, HIGH_SURR | {6'd0, v[19:10]}}, 16), 1'b0,
							COMPUTED, 32'd0);
						send_item(with_junk({16'd0, LOW_SURR | {6'd0, v[9:0]}}, 16), rand_eot(),
							COMPUTED, 32'd0);
					end else begin
						send_item(with_junk(cp, 16), rand_eot(), COMPUTED, 32'd0);
					end
				end
			end
			default: begin
				send_item(cp, rand_eot(), COMPUTED, 32'd0);
			end
		endcase
	endtask

	// Receiver: random idling, and a long hold-off whenever the stimulus asks for one.
	always @(posedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			stall_left <= LONG_STALL;
			m_tready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Output check, sampled mid-cycle while the outputs are stable.
	always @(negedge clk) begin : out_check
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_units.size() == 0) begin
				mismatches++;
				$display("%0t: expected no transaction, got unit %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = pending_units.pop_front();
				if (m_tdata !== want.unit || m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: expected unit %h last %b, got unit %h last %b",
						$time, want.unit, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus: reset, the directed table, then random text in every mode and idle pattern.
	initial begin
		int base;
		send_idle_pct = send_idle_by[0];
		recv_idle_pct = recv_idle_by[0];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != cur_mode) begin
				settle();
				write_mode(dir_rows[i].mode);
			end
			send_item(dir_rows[i].unit, dir_rows[i].eot, dir_rows[i].want_n, dir_rows[i].want);
		end

		for (int r = 0; r < 3; r++) begin
			for (int m = 0; m < 4; m++) begin
				settle();
				send_idle_pct = send_idle_by[r];
				recv_idle_pct = recv_idle_by[r];
				write_mode(mode_t'(m));
				if (r == 2 && m == 0) begin
					// Hold the receiver off while input keeps coming, so the block backs up.
					@(negedge clk);
					stall_req = ~stall_req;
					@(posedge clk);
				end
				// Whole characters until this phase has sent its share of transactions.
				base = sent_items;
				while (sent_items - base < PHASE_ITEMS) begin
					send_text(mode_t'(m));
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
